>>> rtl/icp_pkg.sv
package icp_pkg;

    localparam int MAX_TEXT_LEN_DEFAULT = 18;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;

    localparam logic [11:0] OCTET_MAX  = 12'd255;
    localparam logic [11:0] PREFIX_MAX = 12'd32;
    localparam logic [5:0]  PREFIX_ABSENT = 6'd32;

    localparam logic [1:0] OCTET_DIGITS_MAX  = 2'd3;
    localparam logic [1:0] PREFIX_DIGITS_MAX = 2'd2;
    localparam logic [1:0] LAST_STORED_OCTET = 2'd3;

    // Running parse state for one string, apart from the character count.
    typedef struct packed {
        logic [1:0]      octet_index;
        logic            in_prefix;
        logic [7:0]      accumulator;
        logic [1:0]      digit_count;
        logic            first_digit_zero;
        logic            failed;
        logic [2:0][7:0] stored_octets;
        logic [7:0]      final_octet;
    } parse_state_t;

    typedef struct packed {
        logic        valid_res;
        logic [31:0] address;
        logic [5:0]  prefix_len;
    } parse_result_t;

endpackage

>>> rtl/icp_if.sv
interface icp_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface icp_result_if;
    logic        valid;
    logic        ready;
    logic        valid_res;
    logic [31:0] address;
    logic [5:0]  prefix_len;

    modport source (output valid, output valid_res, output address, output prefix_len,
                    input ready);
    modport sink   (input valid, input valid_res, input address, input prefix_len,
                    output ready);
endinterface

>>> rtl/icp_char_step.sv
module icp_char_step
    import icp_pkg::*;
(
    input  parse_state_t  cur,
    input  logic [7:0]    char_code,
    input  logic          overlong,
    output parse_state_t  nxt,
    output parse_result_t res
);

    logic [3:0]  digit;
    logic [11:0] acc_x10;
    logic [11:0] value;
    logic [1:0]  limit_digits;
    logic [11:0] limit_value;
    logic [7:0]  fourth;

    assign digit        = char_code[3:0];
    // Multiply by ten as 8x + 2x.
    assign acc_x10      = {1'b0, cur.accumulator, 3'b000} + {3'b000, cur.accumulator, 1'b0};
    assign value        = acc_x10 + {8'd0, digit};
    assign limit_digits = cur.in_prefix ? PREFIX_DIGITS_MAX : OCTET_DIGITS_MAX;
    assign limit_value  = cur.in_prefix ? PREFIX_MAX : OCTET_MAX;

    always_comb
    begin
        nxt = cur;
        if (overlong)
        begin
            nxt.failed = 1'b1;
        end
        else if (!cur.failed)
        begin
            case (char_code) inside
                [CHAR_ZERO:CHAR_NINE]:
                begin
                    if (cur.digit_count == 2'd0)
                    begin
                        nxt.first_digit_zero = (digit == 4'd0);
                    end
                    if (cur.digit_count >= limit_digits)
                    begin
                        nxt.failed = 1'b1;
                    end
                    else if (value > limit_value
                             || (cur.digit_count != 2'd0 && cur.first_digit_zero))
                    begin
                        nxt.failed = 1'b1;
                    end
                    else
                    begin
                        nxt.accumulator = value[7:0];
                        nxt.digit_count = cur.digit_count + 2'd1;
                    end
                end
                CHAR_DOT:
                begin
                    if (cur.in_prefix || cur.digit_count == 2'd0
                        || cur.octet_index == LAST_STORED_OCTET)
                    begin
                        nxt.failed = 1'b1;
                    end
                    else
                    begin
                        nxt.stored_octets[cur.octet_index] = cur.accumulator;
                        nxt.octet_index      = cur.octet_index + 2'd1;
                        nxt.accumulator      = 8'd0;
                        nxt.digit_count      = 2'd0;
                        nxt.first_digit_zero = 1'b0;
                    end
                end
                CHAR_SLASH:
                begin
                    if (cur.in_prefix || cur.digit_count == 2'd0
                        || cur.octet_index != LAST_STORED_OCTET)
                    begin
                        nxt.failed = 1'b1;
                    end
                    else
                    begin
                        nxt.final_octet      = cur.accumulator;
                        nxt.in_prefix        = 1'b1;
                        nxt.accumulator      = 8'd0;
                        nxt.digit_count      = 2'd0;
                        nxt.first_digit_zero = 1'b0;
                    end
                end
                default:
                begin
                    nxt.failed = 1'b1;
                end
            endcase
        end
    end

    always_comb
    begin
        res.valid_res = !nxt.failed && nxt.digit_count != 2'd0
                        && nxt.octet_index == LAST_STORED_OCTET;
        fourth = nxt.in_prefix ? nxt.final_octet : nxt.accumulator;
        if (res.valid_res)
        begin
            res.address    = {nxt.stored_octets[0], nxt.stored_octets[1],
                              nxt.stored_octets[2], fourth};
            res.prefix_len = nxt.in_prefix ? nxt.accumulator[5:0] : PREFIX_ABSENT;
        end
        else
        begin
            res.address    = 32'd0;
            res.prefix_len = 6'd0;
        end
    end

endmodule

>>> rtl/ipv4_cidr_text_parser_unit.sv
// IPv4 dotted-quad / CIDR text parser.
//
// The chars channel carries one ASCII character per transfer, with last_char
// marking the final character of a string. Every transfer updates a small
// running state; only the transfer with last_char set produces a result on
// the result channel: valid_res, the 32-bit address (first octet in the top
// byte) and prefix_len (32 when no prefix is given). Rejected strings return
// valid_res low with address and prefix_len zero.
//
// One character is taken every cycle while chars.ready is high. A result
// appears on the result channel in the cycle after its last character is
// taken. The result sits in a single output register; while it waits, the
// parser keeps taking characters as long as the receiver takes the result
// in the same cycle, or the register is empty. A stalled result therefore
// holds chars.ready low, and only then. The state clears itself after every
// string. Reset clears the parse state and empties the output register.
module ipv4_cidr_text_parser_unit
    import icp_pkg::*;
#(
    parameter int MAX_TEXT_LEN = MAX_TEXT_LEN_DEFAULT
)
(
    input  logic                clk,
    input  logic                rst_n,
    icp_char_if.sink            chars,
    icp_result_if.source        result
);

    localparam int CNT_W = $clog2(MAX_TEXT_LEN + 1);

    parse_state_t  state_reg;
    parse_state_t  state_next;
    parse_result_t res_next;
    parse_result_t res_reg;
    logic          out_valid_reg;
    logic [CNT_W-1:0] char_count_reg;
    logic [CNT_W-1:0] char_count_next;
    logic          overlong;
    logic          in_fire;

    assign chars.ready = !out_valid_reg || result.ready;
    assign in_fire     = chars.valid && chars.ready;
    assign overlong    = char_count_reg >= CNT_W'(MAX_TEXT_LEN);

    always_comb
    begin
        if (chars.last_char)
            char_count_next = '0;
        else if (overlong)
            char_count_next = char_count_reg;
        else
            char_count_next = char_count_reg + CNT_W'(1);
    end

    icp_char_step u_step (
        .cur       (state_reg),
        .char_code (chars.char_code),
        .overlong  (overlong),
        .nxt       (state_next),
        .res       (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= '0;
            char_count_reg <= '0;
        end
        else if (in_fire)
        begin
            state_reg      <= chars.last_char ? '0 : state_next;
            char_count_reg <= char_count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_fire && chars.last_char)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && chars.last_char)
            res_reg <= res_next;
    end

    assign result.valid      = out_valid_reg;
    assign result.valid_res  = res_reg.valid_res;
    assign result.address    = res_reg.address;
    assign result.prefix_len = res_reg.prefix_len;

    a_result_follows_last: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && chars.last_char |=> out_valid_reg)
        else $error("no result after the last character");

    a_state_clears: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && chars.last_char |=> char_count_reg == '0 && !state_reg.failed
                                        && state_reg.octet_index == 2'd0)
        else $error("parse state not cleared after a string");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !res_reg.valid_res |-> res_reg.address == 32'd0
                                                && res_reg.prefix_len == 6'd0)
        else $error("rejected string carries nonzero fields");

    a_prefix_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> res_reg.prefix_len <= PREFIX_ABSENT)
        else $error("prefix length above 32");

    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !result.ready |-> !chars.ready)
        else $error("character taken while the result register is blocked");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        char_count_reg <= CNT_W'(MAX_TEXT_LEN))
        else $error("character count beyond the text limit");

endmodule
